>>> hdl/pwm_period_and_duty_calculator_defines.svh
// ----------------------------------------------------------------------------
// PWM calculator assertion macros
// Shared assertion forms for the checker. Each one expects clk and rst_n
// in the scope of the use.
// ----------------------------------------------------------------------------
`ifndef PWM_PERIOD_AND_DUTY_CALCULATOR_DEFINES_SVH
`define PWM_PERIOD_AND_DUTY_CALCULATOR_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define PDC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdc check failed");

// Next-cycle implication, off while reset is asserted
`define PDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdc check failed");

// Next-cycle implication that also runs through reset
`define PDC_ASSERT_RESET(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pdc reset check failed");

`endif

>>> hdl/pdc_pkg.sv
// ----------------------------------------------------------------------------
// PWM calculator package
// Widths, limits, codes and shared types of the PWM period and duty block.
// ----------------------------------------------------------------------------
package pdc_pkg;

  // field and datapath widths
  localparam int unsigned PER_W  = 32;
  localparam int unsigned DUTY_W = 7;
  localparam int unsigned PSC_W  = 16;
  localparam int unsigned PSG_W  = PSC_W + 1;
  localparam int unsigned CHAN_W = 2;
  localparam int unsigned PROD_W = PER_W + DUTY_W;
  localparam int unsigned DVD_W  = PROD_W + 1;
  localparam int unsigned DVS_W  = PER_W;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned MCNT_W = 3;

  // timer limits
  localparam logic [PER_W-1:0]  CORE_CLOCK_RST = 32'd8000000;
  localparam logic [PER_W-1:0]  MAX_PERIOD     = 32'd65535;
  localparam logic [PSG_W-1:0]  MAX_PRESCALE   = 17'd65535;
  localparam logic [PSG_W-1:0]  MIN_PERIOD     = 17'd1;
  localparam logic [CHAN_W:0]   NUM_CHANNELS   = 3'd4;
  localparam logic [DUTY_W-1:0] FULL_DUTY      = 7'd100;

  // divider operands and step counts
  localparam logic [DVS_W-1:0] LIM_DIVISOR = DVS_W'(MIN_PERIOD) + 32'd1;
  localparam logic [CNT_W-1:0] STEPS_CLK   = CNT_W'(PER_W);
  localparam logic [CNT_W-1:0] STEPS_PROD  = CNT_W'(PROD_W);

  // action codes
  localparam logic ACT_FREQ = 1'b0;
  localparam logic ACT_DUTY = 1'b1;

  // divider control
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] steps;
  } pdc_div_ctl_t;

endpackage

>>> hdl/pdc_if.sv
// ----------------------------------------------------------------------------
// PWM calculator channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface pdc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [pdc_pkg::PER_W-1:0]     frequency;
  logic [pdc_pkg::CHAN_W-1:0]    channel;
  logic [pdc_pkg::DUTY_W-1:0]    duty;

  modport source (output valid, action, frequency, channel, duty, input ready);
  modport sink   (input valid, action, frequency, channel, duty, output ready);
endinterface

interface pdc_out_if;
  logic                          valid;
  logic                          ready;
  logic                          counter_enabled;
  logic [pdc_pkg::PSC_W-1:0]     prescale_minus_one;
  logic [pdc_pkg::PER_W-1:0]     period_value;
  logic [pdc_pkg::PER_W-1:0]     compare_value;
  logic [pdc_pkg::CHAN_W-1:0]    compare_channel;
  logic                          compare_valid;
  logic                          full_on_mode;

  modport source (output valid, counter_enabled, prescale_minus_one, period_value,
                  compare_value, compare_channel, compare_valid, full_on_mode,
                  input ready);
  modport sink   (input valid, counter_enabled, prescale_minus_one, period_value,
                  compare_value, compare_channel, compare_valid, full_on_mode,
                  output ready);
endinterface

>>> hdl/pdc_div.sv
// ----------------------------------------------------------------------------
// PWM calculator divider
// Restoring divider, one quotient bit per cycle. The dividend is loaded
// aligned to the top of its register; after the given number of steps the
// low bits of that register hold the quotient.
// ----------------------------------------------------------------------------
module pdc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pdc_pkg::pdc_div_ctl_t       ctl,
  input  logic [pdc_pkg::DVD_W-1:0]   dividend,
  input  logic [pdc_pkg::DVS_W-1:0]   divisor,
  output logic [pdc_pkg::DVD_W-1:0]   quotient,
  output logic                        done
);

  logic [pdc_pkg::DVD_W-1:0] dvd_r;
  logic [pdc_pkg::DVS_W-1:0] rem_r;
  logic [pdc_pkg::DVS_W-1:0] dvs_r;
  logic [pdc_pkg::CNT_W-1:0] cnt_r;
  logic                      busy_r;
  logic                      done_r;

  logic [pdc_pkg::DVS_W:0]   trial;
  logic                      fits;

  // trial subtract of the divisor from the shifted remainder
  assign trial = {rem_r, dvd_r[pdc_pkg::DVD_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= ctl.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == pdc_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath: shift dividend out, quotient bits in
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= pdc_pkg::DVS_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_r <= trial[pdc_pkg::DVS_W-1:0];
      end
      dvd_r <= {dvd_r[pdc_pkg::DVD_W-2:0], fits};
    end
  end

  assign quotient = dvd_r;
  assign done     = done_r;

endmodule

>>> hdl/pdc_mul.sv
// ----------------------------------------------------------------------------
// PWM calculator duty multiplier
// Shift-add multiplier, one duty bit per cycle: period times duty.
// ----------------------------------------------------------------------------
module pdc_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [pdc_pkg::PER_W-1:0]    period,
  input  logic [pdc_pkg::DUTY_W-1:0]   duty,
  output logic [pdc_pkg::PROD_W-1:0]   prod,
  output logic                         done
);

  logic [pdc_pkg::PROD_W-1:0] acc_r;
  logic [pdc_pkg::PROD_W-1:0] mcand_r;
  logic [pdc_pkg::DUTY_W-1:0] mplier_r;
  logic [pdc_pkg::MCNT_W-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= pdc_pkg::MCNT_W'(pdc_pkg::DUTY_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == pdc_pkg::MCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // add the shifted period for each set duty bit
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r    <= '0;
      mcand_r  <= pdc_pkg::PROD_W'(period);
      mplier_r <= duty;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= {mcand_r[pdc_pkg::PROD_W-2:0], 1'b0};
      mplier_r <= {1'b0, mplier_r[pdc_pkg::DUTY_W-1:1]};
    end
  end

  assign prod = acc_r;
  assign done = done_r;

endmodule

>>> hdl/pwm_period_and_duty_calculator.sv
// ----------------------------------------------------------------------------
// PWM period and duty calculator
// Timer prescaler/period from a requested frequency, compare value from a
// duty percentage.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : request beats (action, frequency, channel, duty). One request
//            is worked on at a time; in_ch.ready is high while idle.
//   out_ch : one result beat per request, held in an output register, so
//            a new request is taken while a result still waits.
//   cfg_we/cfg_wdata : write the timer input clock in hertz; write only
//            while no request is in flight.
// Steps from accept to result:
//   frequency zero, or duty on a missing channel : no arithmetic steps
//   duty item  : 7 multiply steps, then 39 divide steps
//   frequency  : two 32-step divisions, then up to 16 prescaler
//                doubling steps; only the limit division when the clock is
//                below two hertz
//   Nearly all of the steps run on the single bit-per-cycle divider.
// The next request is taken only after the result of the last one has
//   entered the output register and the block is back in idle.
// Reset clears the stored period, prescaler, run and full-on flags, loads
// the clock register with 8 MHz and empties the output register.
// A stalled receiver holds the result; the next result waits in the
// done state until the output register frees.
// ----------------------------------------------------------------------------
module pwm_period_and_duty_calculator (
  input  logic                       clk,
  input  logic                       rst_n,
  pdc_in_if.sink                     in_ch,
  pdc_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [pdc_pkg::PER_W-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIM,
    S_QDIV,
    S_SRCH,
    S_MUL,
    S_DDIV,
    S_DONE
  } state_t;

  state_t state_r;

  logic [pdc_pkg::PER_W-1:0]  core_clock_r;
  logic [pdc_pkg::PER_W-1:0]  stored_period_r;
  logic [pdc_pkg::PSC_W-1:0]  stored_prescale_r;
  logic                       running_r;
  logic                       full_r;

  logic [pdc_pkg::PER_W-1:0]  f_r;
  logic [pdc_pkg::PER_W-1:0]  q_r;
  logic                       fzero_r;
  logic [pdc_pkg::PSG_W-1:0]  psg_r;
  logic [pdc_pkg::DUTY_W-1:0] duty_r;
  logic [pdc_pkg::PER_W-1:0]  cmp_r;
  logic [pdc_pkg::CHAN_W-1:0] cchan_r;
  logic                       cvld_r;
  logic                       div_start_r;
  logic                       mul_start_r;

  logic                       out_valid_r;
  logic                       o_run_r;
  logic [pdc_pkg::PSC_W-1:0]  o_psc_r;
  logic [pdc_pkg::PER_W-1:0]  o_per_r;
  logic [pdc_pkg::PER_W-1:0]  o_cmp_r;
  logic [pdc_pkg::CHAN_W-1:0] o_chan_r;
  logic                       o_cvld_r;
  logic                       o_full_r;

  pdc_pkg::pdc_div_ctl_t      div_ctl;
  logic [pdc_pkg::DVD_W-1:0]  div_dvd;
  logic [pdc_pkg::DVS_W-1:0]  div_dvs;
  logic [pdc_pkg::DVD_W-1:0]  div_quo;
  logic                       div_done;
  logic [pdc_pkg::PROD_W-1:0] mul_prod;
  logic                       mul_done;

  logic                       in_acc;
  logic                       out_free;
  logic [pdc_pkg::PER_W-1:0]  limit;
  logic [pdc_pkg::PER_W-1:0]  f_clamp;
  logic [pdc_pkg::PER_W-1:0]  per;
  logic [pdc_pkg::PSG_W-1:0]  psg_m1;
  logic                       grow;
  logic [pdc_pkg::DUTY_W-1:0] duty_clamp;
  logic                       chan_ok;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // clamp of the request against the clock limit
  assign limit   = div_quo[pdc_pkg::PER_W-1:0];
  assign f_clamp = (f_r > limit) ? limit : f_r;

  // prescaler search step
  assign per    = q_r - 32'd1;
  assign psg_m1 = psg_r - 17'd1;
  assign grow   = (per >= pdc_pkg::MAX_PERIOD) && (psg_r <= pdc_pkg::MAX_PRESCALE);

  // duty request decode
  assign duty_clamp = (in_ch.duty > pdc_pkg::FULL_DUTY) ? pdc_pkg::FULL_DUTY : in_ch.duty;
  assign chan_ok    = ({1'b0, in_ch.channel} < pdc_pkg::NUM_CHANNELS);

  // divider operand select by phase
  always_comb begin
    div_ctl.start = div_start_r;
    unique case (state_r)
      S_DDIV: begin
        div_ctl.steps = pdc_pkg::STEPS_PROD;
        div_dvd       = {mul_prod, 1'b0};
        div_dvs       = pdc_pkg::DVS_W'(pdc_pkg::FULL_DUTY);
      end
      S_QDIV: begin
        div_ctl.steps = pdc_pkg::STEPS_CLK;
        div_dvd       = {core_clock_r, {(pdc_pkg::DVD_W-pdc_pkg::PER_W){1'b0}}};
        div_dvs       = f_r;
      end
      default: begin
        div_ctl.steps = pdc_pkg::STEPS_CLK;
        div_dvd       = {core_clock_r, {(pdc_pkg::DVD_W-pdc_pkg::PER_W){1'b0}}};
        div_dvs       = pdc_pkg::LIM_DIVISOR;
      end
    endcase
  end

  pdc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .done     (div_done)
  );

  pdc_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start_r),
    .period (stored_period_r),
    .duty   (duty_r),
    .prod   (mul_prod),
    .done   (mul_done)
  );

  // sequencer with stored timer state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= S_IDLE;
      core_clock_r      <= pdc_pkg::CORE_CLOCK_RST;
      stored_period_r   <= '0;
      stored_prescale_r <= '0;
      running_r         <= 1'b0;
      full_r            <= 1'b0;
      div_start_r       <= 1'b0;
      mul_start_r       <= 1'b0;
      out_valid_r       <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      mul_start_r <= 1'b0;
      if (cfg_we) begin
        core_clock_r <= cfg_wdata;
      end
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            f_r    <= in_ch.frequency;
            cmp_r  <= '0;
            cvld_r <= 1'b0;
            if (in_ch.action == pdc_pkg::ACT_FREQ) begin
              cchan_r <= '0;
              if (in_ch.frequency == '0) begin
                running_r <= 1'b0;
                state_r   <= S_DONE;
              end else begin
                div_start_r <= 1'b1;
                state_r     <= S_LIM;
              end
            end else begin
              cchan_r <= in_ch.channel;
              duty_r  <= duty_clamp;
              if (chan_ok) begin
                mul_start_r <= 1'b1;
                state_r     <= S_MUL;
              end else begin
                state_r <= S_DONE;
              end
            end
          end
        end

        S_LIM: begin
          if (div_done) begin
            f_r   <= f_clamp;
            psg_r <= pdc_pkg::PSG_W'(1);
            if (f_clamp == '0) begin
              // no valid divisor: quotient saturates for every prescaler
              q_r     <= '1;
              fzero_r <= 1'b1;
              state_r <= S_SRCH;
            end else begin
              fzero_r     <= 1'b0;
              div_start_r <= 1'b1;
              state_r     <= S_QDIV;
            end
          end
        end

        S_QDIV: begin
          if (div_done) begin
            q_r     <= div_quo[pdc_pkg::PER_W-1:0];
            state_r <= S_SRCH;
          end
        end

        S_SRCH: begin
          // doubling the prescaler halves the quotient
          if (grow) begin
            psg_r <= {psg_r[pdc_pkg::PSG_W-2:0], 1'b0};
            if (!fzero_r) begin
              q_r <= {1'b0, q_r[pdc_pkg::PER_W-1:1]};
            end
          end else begin
            stored_period_r   <= per;
            stored_prescale_r <= psg_m1[pdc_pkg::PSC_W-1:0];
            running_r         <= 1'b1;
            state_r           <= S_DONE;
          end
        end

        S_MUL: begin
          if (mul_done) begin
            div_start_r <= 1'b1;
            state_r     <= S_DDIV;
          end
        end

        S_DDIV: begin
          if (div_done) begin
            cmp_r   <= div_quo[pdc_pkg::PER_W-1:0];
            cvld_r  <= 1'b1;
            full_r  <= (duty_r == pdc_pkg::FULL_DUTY);
            state_r <= S_DONE;
          end
        end

        S_DONE: begin
          // hand the result to the output register once it frees
          if (out_free) begin
            out_valid_r <= 1'b1;
            o_run_r     <= running_r;
            o_psc_r     <= stored_prescale_r;
            o_per_r     <= stored_period_r;
            o_cmp_r     <= cmp_r;
            o_chan_r    <= cchan_r;
            o_cvld_r    <= cvld_r;
            o_full_r    <= full_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready               = (state_r == S_IDLE);
  assign out_ch.valid              = out_valid_r;
  assign out_ch.counter_enabled    = o_run_r;
  assign out_ch.prescale_minus_one = o_psc_r;
  assign out_ch.period_value       = o_per_r;
  assign out_ch.compare_value      = o_cmp_r;
  assign out_ch.compare_channel    = o_chan_r;
  assign out_ch.compare_valid      = o_cvld_r;
  assign out_ch.full_on_mode       = o_full_r;

endmodule

>>> hdl/pdc_checker.sv
// ----------------------------------------------------------------------------
// PWM calculator checker
// Port-level checks of the PWM period and duty calculator, bound to the top.
// ----------------------------------------------------------------------------
`include "pwm_period_and_duty_calculator_defines.svh"

module pdc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [pdc_pkg::PER_W-1:0]  period_value,
  input logic [pdc_pkg::PER_W-1:0]  compare_value,
  input logic                       compare_valid,
  input logic                       full_on_mode
);

  // one request at a time: the accepting beat closes the input
  `PDC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a stalled result beat holds
  `PDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(compare_value))

  // duty never exceeds 100 percent of the period
  `PDC_ASSERT_SAME(a_cmp_le_period, out_valid && compare_valid, compare_value <= period_value)

  // full-on compare write carries the whole period
  `PDC_ASSERT_SAME(a_full_cmp, out_valid && compare_valid && full_on_mode,
                   compare_value == period_value)

  // reset empties the result register and opens the input
  `PDC_ASSERT_RESET(a_reset_state, !rst_n, !out_valid && in_ready)

endmodule

bind pwm_period_and_duty_calculator pdc_checker u_pdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .period_value  (out_ch.period_value),
  .compare_value (out_ch.compare_value),
  .compare_valid (out_ch.compare_valid),
  .full_on_mode  (out_ch.full_on_mode)
);

>>> test/pdc_checker.sv
// ----------------------------------------------------------------------------
// PWM calculator scoreboard
// Watches the request, result and clock-register ports, works out each
// result from a private copy of the timer state and checks every result
// beat field by field, in order.
// ----------------------------------------------------------------------------
module pdc_scoreboard (
  input  logic                      clk,
  input  logic                      rst_n,
  pdc_in_if                         in_mon,
  pdc_out_if                        out_mon,
  input  logic                      cfg_we,
  input  logic [pdc_pkg::PER_W-1:0] cfg_wdata,
  output int                        errors,
  output int                        pending
);

  localparam int unsigned FW = pdc_pkg::PER_W;

  typedef struct packed {
    logic                       counter_enabled;
    logic [pdc_pkg::PSC_W-1:0]  prescale;
    logic [pdc_pkg::PER_W-1:0]  period;
    logic [pdc_pkg::PER_W-1:0]  compare;
    logic [pdc_pkg::CHAN_W-1:0] chan;
    logic                       compare_valid;
    logic                       full_on;
  } timer_result_t;

  // private timer state
  logic [pdc_pkg::PER_W-1:0] core_hz    = pdc_pkg::CORE_CLOCK_RST;
  logic [pdc_pkg::PER_W-1:0] period_q   = '0;
  logic [pdc_pkg::PSC_W-1:0] prescale_q = '0;
  logic                      running_q  = 1'b0;
  logic                      full_on_q  = 1'b0;

  timer_result_t timer_results[$];
  int            fail_count = 0;
  int            outstanding = 0;

  assign errors  = fail_count;
  assign pending = outstanding;

  // Apply one request to the timer state and return the result it gives
  function automatic timer_result_t apply_request(input logic act,
                                                  input logic [pdc_pkg::PER_W-1:0] freq,
                                                  input logic [pdc_pkg::CHAN_W-1:0] chan,
                                                  input logic [pdc_pkg::DUTY_W-1:0] duty);
    timer_result_t r;
    logic [63:0]   f;
    logic [63:0]   limit;
    logic [63:0]   psg;
    logic [63:0]   den;
    logic [63:0]   quo;
    logic [63:0]   per;
    logic [63:0]   cmp;
    logic [pdc_pkg::DUTY_W-1:0] d;
    logic          grow;
    r = '0;
    if (act == pdc_pkg::ACT_FREQ) begin
      if (freq == '0) begin
        running_q = 1'b0;
      end else begin
        // clamp to the fastest rate the minimum period allows
        limit = 64'(core_hz) / 64'(pdc_pkg::LIM_DIVISOR);
        f = 64'(freq);
        if (f > limit) f = limit;
        // double the prescaler until the period fits
        psg  = 64'd1;
        grow = 1'b1;
        while (grow) begin
          den = f * psg;
          quo = (den == 64'd0) ? 64'hFFFF_FFFF : 64'(core_hz) / den;
          per = (quo - 64'd1) & 64'hFFFF_FFFF;
          grow = (per >= 64'(pdc_pkg::MAX_PERIOD)) && (psg <= 64'(pdc_pkg::MAX_PRESCALE));
          if (grow) psg = psg << 1;
        end
        prescale_q = pdc_pkg::PSC_W'(psg - 64'd1);
        period_q   = pdc_pkg::PER_W'(per);
        running_q  = 1'b1;
      end
    end else begin
      r.chan = chan;
      if ({1'b0, chan} < pdc_pkg::NUM_CHANNELS) begin
        // duty above full scale counts as full scale
        d = (duty > pdc_pkg::FULL_DUTY) ? pdc_pkg::FULL_DUTY : duty;
        cmp = (64'(period_q) * 64'(d)) / 64'(pdc_pkg::FULL_DUTY);
        r.compare       = pdc_pkg::PER_W'(cmp);
        r.compare_valid = 1'b1;
        full_on_q       = (d >= pdc_pkg::FULL_DUTY);
      end
    end
    r.counter_enabled = running_q;
    r.prescale        = prescale_q;
    r.period          = period_q;
    r.full_on         = full_on_q;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [pdc_pkg::PER_W-1:0] want,
                             input logic [pdc_pkg::PER_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    end
  endtask

  // Track register writes, check result beats, then predict request beats
  always @(posedge clk) begin : watch
    timer_result_t want;
    if (!rst_n) begin
      core_hz    = pdc_pkg::CORE_CLOCK_RST;
      period_q   = '0;
      prescale_q = '0;
      running_q  = 1'b0;
      full_on_q  = 1'b0;
      timer_results.delete();
    end else begin
      if (cfg_we) core_hz = cfg_wdata;
      if (out_mon.valid && out_mon.ready) begin
        if (timer_results.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with no request outstanding", $time);
        end else begin
          want = timer_results.pop_front();
          check_field("counter_enabled", FW'(want.counter_enabled),
                      FW'(out_mon.counter_enabled));
          check_field("prescale_minus_one", FW'(want.prescale),
                      FW'(out_mon.prescale_minus_one));
          check_field("period_value", want.period, out_mon.period_value);
          check_field("compare_value", want.compare, out_mon.compare_value);
          check_field("compare_channel", FW'(want.chan), FW'(out_mon.compare_channel));
          check_field("compare_valid", FW'(want.compare_valid),
                      FW'(out_mon.compare_valid));
          check_field("full_on_mode", FW'(want.full_on), FW'(out_mon.full_on_mode));
        end
      end
      if (in_mon.valid && in_mon.ready)
        timer_results.push_back(apply_request(in_mon.action, in_mon.frequency,
                                              in_mon.channel, in_mon.duty));
    end
    outstanding = timer_results.size();
  end

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// PWM calculator testbench
// Drives directed and random frequency and duty requests over a range of
// timer clock settings, with random gaps and stalls on both channels and
// one long result hold-off; the scoreboard beside the block checks results.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 10;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_GAP = 16;
  localparam int SETTLE_CYCLES = 100;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_ITEMS = 103;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [pdc_pkg::PER_W-1:0] cfg_wdata = '0;

  int                        tx_idle_pct = 0;
  int                        rx_idle_pct = 0;
  bit                        rx_hold_req = 1'b0;
  logic [pdc_pkg::PER_W-1:0] cur_clock = pdc_pkg::CORE_CLOCK_RST;
  logic [pdc_pkg::PER_W-1:0] clock_plan [0:NUM_PHASES-1];
  int                        errors;
  int                        pending;
  int                        stall_cycles = 0;

  pdc_in_if  in_ch ();
  pdc_out_if out_ch ();

  pwm_period_and_duty_calculator DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pdc_scoreboard u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always #HALF_PERIOD clk = ~clk;

  // Abort when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("pwm_period_and_duty_calculator regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Offer one request beat, with random gaps ahead of it, and hold it until taken
  task automatic send_req(input logic act, input logic [pdc_pkg::PER_W-1:0] freq,
                          input logic [pdc_pkg::CHAN_W-1:0] chan,
                          input logic [pdc_pkg::DUTY_W-1:0] duty);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.frequency <= freq;
    in_ch.channel   <= chan;
    in_ch.duty      <= duty;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every result is out and the block is idle
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_GAP) @(negedge clk);
  endtask

  task automatic write_clock(input logic [pdc_pkg::PER_W-1:0] hz);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_clock = hz;
  endtask

  function automatic logic [pdc_pkg::PER_W-1:0] pick_frequency();
    logic [pdc_pkg::PER_W-1:0] limit;
    limit = cur_clock / pdc_pkg::LIM_DIVISOR;
    case ($urandom_range(0, 9)) inside
      0:       return '0;
      [1:2]:   return $urandom;
      [3:4]:   return $urandom_range(1, 5000);
      [5:7]:   return cur_clock / $urandom_range(1, 1 << 22);
      8:       return limit + $urandom_range(0, 2) - 1;
      default: return 32'hFFFF_FFFF - $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [pdc_pkg::DUTY_W-1:0] pick_duty();
    case ($urandom_range(0, 7))
      0:       return pdc_pkg::DUTY_W'($urandom_range(101, 127));
      1:       return pdc_pkg::FULL_DUTY;
      2:       return '0;
      default: return pdc_pkg::DUTY_W'($urandom_range(0, 100));
    endcase
  endfunction

  initial begin : stimulus
    in_ch.valid     = 1'b0;
    in_ch.action    = pdc_pkg::ACT_FREQ;
    in_ch.frequency = '0;
    in_ch.channel   = '0;
    in_ch.duty      = '0;
    clock_plan = '{32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'd72000000, 32'd65536,
                   32'd1000, $urandom, $urandom_range(2, 1 << 24), 32'd8000000,
                   32'h8000_0000, $urandom};

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset clock, no idling
    send_req(pdc_pkg::ACT_DUTY, '0, 2'd0, 7'd50);             // duty before any period
    send_req(pdc_pkg::ACT_FREQ, '0, '0, '0);                  // stop while stopped
    send_req(pdc_pkg::ACT_FREQ, 32'd1000, '0, '0);
    send_req(pdc_pkg::ACT_DUTY, '0, 2'd1, '0);                // zero duty
    send_req(pdc_pkg::ACT_DUTY, '0, 2'd2, pdc_pkg::FULL_DUTY); // enter full-on
    send_req(pdc_pkg::ACT_DUTY, '0, 2'd3, 7'd99);             // leave full-on
    send_req(pdc_pkg::ACT_FREQ, 32'd1, '0, '0);               // deepest prescaler doubling
    send_req(pdc_pkg::ACT_DUTY, '0, 2'd0, 7'd127);            // duty above full scale
    send_req(pdc_pkg::ACT_DUTY, '0, 2'd1, 7'd101);
    send_req(pdc_pkg::ACT_FREQ, 32'hFFFF_FFFF, '0, '0);       // clamped to the limit
    send_req(pdc_pkg::ACT_FREQ, 32'd4000000, '0, '0);
    send_req(pdc_pkg::ACT_FREQ, 32'd4000001, '0, '0);
    send_req(pdc_pkg::ACT_FREQ, 32'd122, '0, '0);             // period just over the max
    send_req(pdc_pkg::ACT_FREQ, 32'd123, '0, '0);
    send_req(pdc_pkg::ACT_DUTY, '0, 2'd3, pdc_pkg::FULL_DUTY);
    send_req(pdc_pkg::ACT_FREQ, '0, '0, '0);                  // stop keeps period
    send_req(pdc_pkg::ACT_DUTY, '0, 2'd2, 7'd1);
    send_req(pdc_pkg::ACT_FREQ, 32'h8000_0000, '0, '0);
    send_req(pdc_pkg::ACT_DUTY, '0, 2'd3, 7'd33);
    drain_block();

    // Random phases over the clock plan and three idling patterns
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < NUM_PHASES / 3) begin
        tx_idle_pct = 25;
        rx_idle_pct = 87;
      end else if (phase < 2 * NUM_PHASES / 3) begin
        tx_idle_pct = 87;
        rx_idle_pct = 25;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_clock(clock_plan[phase]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 20) rx_hold_req = 1'b1;
        if ($urandom_range(0, 9) < 4)
          send_req(pdc_pkg::ACT_FREQ, pick_frequency(), pdc_pkg::CHAN_W'($urandom),
                   pdc_pkg::DUTY_W'($urandom));
        else
          send_req(pdc_pkg::ACT_DUTY, $urandom, pdc_pkg::CHAN_W'($urandom), pick_duty());
      end
      drain_block();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("pwm_period_and_duty_calculator regression: pass");
    end else begin
      $display("pwm_period_and_duty_calculator regression: fail");
    end
    $finish;
  end

endmodule
